FILE: rtl/core/ibp_pkg.sv
// ibp_pkg: shared types and constants for the image border padding block.
// Depends on nothing; used by every module under rtl/core.
package ibp_pkg;

    // Input word opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Padding modes
    localparam logic [1:0] MODE_FILL   = 2'd0;
    localparam logic [1:0] MODE_CLAMP  = 2'd1;
    localparam logic [1:0] MODE_MIRROR = 2'd2;
    localparam logic [1:0] MODE_WRAP   = 2'd3;

    // Configuration register indexes
    localparam int REG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam logic [REG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_PAD_TOP       = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_PAD_BOTTOM    = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_PAD_LEFT      = 3'd4;
    localparam logic [REG_INDEX_W-1:0] REG_PAD_RIGHT     = 3'd5;
    localparam logic [REG_INDEX_W-1:0] REG_PAD_MODE      = 3'd6;
    localparam logic [REG_INDEX_W-1:0] REG_FILL_VALUE    = 3'd7;

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_LIT = 2'd0;  // result is the carried value, no memory access
    localparam logic [1:0] CMD_WR  = 2'd1;  // store pixel, result 0 / ok
    localparam logic [1:0] CMD_RD  = 2'd2;  // result comes from the frame store

    typedef struct packed {
        logic       opcode;
        logic [1:0] channel;
        logic [8:0] coord_x;
        logic [8:0] coord_y;
        logic [7:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       status;
    } out_word_t;

    typedef struct packed {
        logic [7:0] source_width;
        logic [7:0] source_height;
        logic [6:0] pad_top;
        logic [6:0] pad_bottom;
        logic [6:0] pad_left;
        logic [6:0] pad_right;
        logic [1:0] pad_mode;
        logic [7:0] fill_value;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] channel;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] value;
        logic       status;
    } cmd_t;

endpackage

FILE: rtl/core/ibp_front.sv
// ibp_front: classifies an input word and maps padded coordinates to source ones.
// Depends on ibp_pkg; feeds ibp_cmd_queue.
module ibp_front #(
    parameter int MAX_WIDTH    = 128,
    parameter int MAX_HEIGHT   = 128,
    parameter int MAX_CHANNELS = 3
) (
    input  ibp_pkg::in_word_t in_word,
    input  ibp_pkg::cfg_t     cfg,
    output ibp_pkg::cmd_t     cmd
);

    // Returns {in_src, source coordinate} for one axis.
    function automatic logic [8:0] map_axis(
        input logic [8:0] p,
        input logic [6:0] pre,
        input logic [7:0] n,
        input logic [1:0] mode
    );
        logic [8:0] last;
        logic [6:0] d_lo;
        logic [8:0] d_hi;
        logic [7:0] s;
        logic       in_src;
        last   = {2'b00, pre} + {1'b0, n};
        d_lo   = pre - p[6:0];
        d_hi   = p - last;
        in_src = (p >= {2'b00, pre}) && (p < last);
        if (in_src)
        begin
            s = 8'(p - {2'b00, pre});
        end
        else if (p < {2'b00, pre})
        begin
            case (mode)
                ibp_pkg::MODE_CLAMP:  s = 8'd0;
                ibp_pkg::MODE_MIRROR: s = {1'b0, d_lo} - 8'd1;
                default:              s = n - {1'b0, d_lo};
            endcase
        end
        else
        begin
            case (mode)
                ibp_pkg::MODE_CLAMP:  s = n - 8'd1;
                ibp_pkg::MODE_MIRROR: s = n - 8'd1 - d_hi[7:0];
                default:              s = d_hi[7:0];
            endcase
        end
        return {in_src, s};
    endfunction

    logic       geom_ok;
    logic       chan_ok;
    logic [9:0] dst_w;
    logic [9:0] dst_h;
    logic       wide;
    logic [8:0] map_x;
    logic [8:0] map_y;

    assign geom_ok = (cfg.source_width != 8'd0) && (32'(cfg.source_width) <= MAX_WIDTH) &&
                     (cfg.source_height != 8'd0) && (32'(cfg.source_height) <= MAX_HEIGHT);
    assign chan_ok = 32'(in_word.channel) < MAX_CHANNELS;

    assign dst_w = {2'b00, cfg.source_width} + {3'b000, cfg.pad_left} +
                   {3'b000, cfg.pad_right};
    assign dst_h = {2'b00, cfg.source_height} + {3'b000, cfg.pad_top} +
                   {3'b000, cfg.pad_bottom};

    // mirror and wrap cannot reach past one source width or height of padding
    assign wide = ((cfg.pad_mode == ibp_pkg::MODE_MIRROR) ||
                   (cfg.pad_mode == ibp_pkg::MODE_WRAP)) &&
                  (({1'b0, cfg.pad_top} > cfg.source_height) ||
                   ({1'b0, cfg.pad_bottom} > cfg.source_height) ||
                   ({1'b0, cfg.pad_left} > cfg.source_width) ||
                   ({1'b0, cfg.pad_right} > cfg.source_width));

    assign map_x = map_axis(in_word.coord_x, cfg.pad_left, cfg.source_width, cfg.pad_mode);
    assign map_y = map_axis(in_word.coord_y, cfg.pad_top, cfg.source_height, cfg.pad_mode);

    always_comb
    begin
        cmd         = '0;
        cmd.kind    = ibp_pkg::CMD_LIT;
        cmd.channel = in_word.channel;
        cmd.value   = 8'd0;
        cmd.status  = 1'b1;
        if (geom_ok && chan_ok)
        begin
            if (in_word.opcode == ibp_pkg::OP_WRITE)
            begin
                if ((in_word.coord_x < {1'b0, cfg.source_width}) &&
                    (in_word.coord_y < {1'b0, cfg.source_height}))
                begin
                    cmd.kind   = ibp_pkg::CMD_WR;
                    cmd.sx     = in_word.coord_x[7:0];
                    cmd.sy     = in_word.coord_y[7:0];
                    cmd.value  = in_word.pixel_in;
                    cmd.status = 1'b0;
                end
            end
            else if (({1'b0, in_word.coord_x} < dst_w) &&
                     ({1'b0, in_word.coord_y} < dst_h) && !wide)
            begin
                cmd.status = 1'b0;
                if ((cfg.pad_mode == ibp_pkg::MODE_FILL) && !(map_x[8] && map_y[8]))
                begin
                    cmd.value = cfg.fill_value;
                end
                else
                begin
                    cmd.kind = ibp_pkg::CMD_RD;
                    cmd.sx   = map_x[7:0];
                    cmd.sy   = map_y[7:0];
                end
            end
        end
    end

endmodule

FILE: rtl/core/ibp_cmd_queue.sv
// ibp_cmd_queue: two-entry command queue between the front and the back.
// Depends on ibp_pkg.
module ibp_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ibp_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          valid,
    input  logic          pop,
    output ibp_pkg::cmd_t head_cmd
);

    localparam int DEPTH = 2;

    ibp_pkg::cmd_t entry_reg [DEPTH];
    logic          head_reg, head_next;
    logic          tail_reg, tail_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == 2'(DEPTH));
    assign valid    = (count_reg != 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign head_cmd = entry_reg[head_reg];

    always_comb
    begin
        head_next  = do_pop  ? ~head_reg : head_reg;
        tail_next  = do_push ? ~tail_reg : tail_reg;
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[tail_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/ibp_back.sv
// ibp_back: frame store access and result queue.
// Depends on ibp_pkg; takes commands from ibp_cmd_queue.
module ibp_back #(
    parameter int MAX_WIDTH    = 128,
    parameter int MAX_HEIGHT   = 128,
    parameter int MAX_CHANNELS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  ibp_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output ibp_pkg::out_word_t out_word
);

    localparam int PLANE    = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH    = PLANE * MAX_CHANNELS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;

    logic [7:0]         store [DEPTH];
    logic [ADDR_W-1:0]  addr;
    logic               issue;
    logic [7:0]         rd_data_reg;

    logic               s1_valid_reg;
    logic               s1_use_mem_reg;
    logic [7:0]         s1_pixel_reg;
    logic               s1_status_reg;
    logic               use_mem;
    logic [7:0]         lit_pixel;
    ibp_pkg::out_word_t result;

    ibp_pkg::out_word_t  oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_head_reg, oq_head_next;
    logic [OQ_PTR_W-1:0] oq_tail_reg, oq_tail_next;
    logic [OQ_PTR_W:0]   oq_count_reg, oq_count_next;
    logic                oq_pop;

    // room must cover the word already in the read stage
    assign issue   = cmd_valid && ((32'(oq_count_reg) + 32'(s1_valid_reg)) < OQ_DEPTH);
    assign cmd_pop = issue;
    assign addr    = ADDR_W'(32'(cmd.channel) * PLANE + 32'(cmd.sy) * MAX_WIDTH +
                             32'(cmd.sx));

    always_comb
    begin
        unique case (cmd.kind)
            ibp_pkg::CMD_RD:
            begin
                use_mem   = 1'b1;
                lit_pixel = 8'd0;
            end
            ibp_pkg::CMD_WR:
            begin
                use_mem   = 1'b0;
                lit_pixel = 8'd0;
            end
            default:
            begin
                use_mem   = 1'b0;
                lit_pixel = cmd.value;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            if (cmd.kind == ibp_pkg::CMD_WR)
            begin
                store[addr] <= cmd.value;
            end
            rd_data_reg    <= store[addr];
            s1_use_mem_reg <= use_mem;
            s1_pixel_reg   <= lit_pixel;
            s1_status_reg  <= cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
        end
    end

    assign result.pixel_out = s1_use_mem_reg ? rd_data_reg : s1_pixel_reg;
    assign result.status    = s1_status_reg;

    // result queue
    assign empty    = (oq_count_reg == '0);
    assign oq_pop   = pop && !empty;
    assign out_word = oq_reg[oq_head_reg];

    always_comb
    begin
        oq_head_next  = oq_pop ? oq_head_reg + OQ_PTR_W'(1) : oq_head_reg;
        oq_tail_next  = s1_valid_reg ? oq_tail_reg + OQ_PTR_W'(1) : oq_tail_reg;
        oq_count_next = oq_count_reg + (OQ_PTR_W+1)'(s1_valid_reg) -
                        (OQ_PTR_W+1)'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_head_reg  <= '0;
            oq_tail_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            oq_head_reg  <= oq_head_next;
            oq_tail_reg  <= oq_tail_next;
            oq_count_reg <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            oq_reg[oq_tail_reg] <= result;
        end
    end

`ifndef ASSERT_OFF
    // a word in the read stage always finds a free slot
    a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (32'(oq_count_reg) < OQ_DEPTH))
        else $error("result queue overflow");

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(oq_count_reg) <= OQ_DEPTH)
        else $error("result queue count out of range");

    // a waiting command is held back only by a full result path
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !issue) |-> ((32'(oq_count_reg) + 32'(s1_valid_reg)) == OQ_DEPTH))
        else $error("command stalled without back pressure");

    a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> s1_valid_reg)
        else $error("issued command lost");
`endif

endmodule

FILE: rtl/core/image_border_padding.sv
// image_border_padding: top level of the border padding engine.
// Depends on ibp_pkg, ibp_front, ibp_cmd_queue and ibp_back.
//
// Channel   Handshake            Word
// -------   ------------------   ------------------------------------------
// input     push / full          in_word  (opcode, channel, coord_x/y, pixel)
// result    pop / empty          out_word (pixel_out, status)
// config    cfg_valid/cfg_ready  cfg_index (register), cfg_data (value)
//
// Sustained rate is one word per cycle while results are popped; the single
// frame store port does one write or one read per cycle. An accepted word
// passes the command queue, store read stage and result queue to the output.
// Reset clears queue and control state and sets the registers to their reset
// values; the frame store is not cleared, so no clearing pass is needed.
// Input and result sides stall independently: the command queue decouples
// the front, the four-word result queue absorbs a stalled pop. cfg_ready is
// always high; the user must write registers while idle, which is unchecked.
module image_border_padding #(
    parameter int MAX_WIDTH    = 128,
    parameter int MAX_HEIGHT   = 128,
    parameter int MAX_CHANNELS = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  ibp_pkg::in_word_t                   in_word,
    output logic                                empty,
    input  logic                                pop,
    output ibp_pkg::out_word_t                  out_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ibp_pkg::REG_INDEX_W-1:0]     cfg_index,
    input  logic [ibp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers
    logic [7:0] source_width_reg;
    logic [7:0] source_height_reg;
    logic [6:0] pad_top_reg;
    logic [6:0] pad_bottom_reg;
    logic [6:0] pad_left_reg;
    logic [6:0] pad_right_reg;
    logic [1:0] pad_mode_reg;
    logic [7:0] fill_value_reg;
    logic       cfg_write;

    ibp_pkg::cfg_t cfg;
    ibp_pkg::cmd_t front_cmd;
    ibp_pkg::cmd_t head_cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= 8'd128;
            source_height_reg <= 8'd128;
            pad_top_reg       <= 7'd0;
            pad_bottom_reg    <= 7'd0;
            pad_left_reg      <= 7'd0;
            pad_right_reg     <= 7'd0;
            pad_mode_reg      <= ibp_pkg::MODE_FILL;
            fill_value_reg    <= 8'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ibp_pkg::REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                ibp_pkg::REG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                ibp_pkg::REG_PAD_TOP:       pad_top_reg       <= cfg_data[6:0];
                ibp_pkg::REG_PAD_BOTTOM:    pad_bottom_reg    <= cfg_data[6:0];
                ibp_pkg::REG_PAD_LEFT:      pad_left_reg      <= cfg_data[6:0];
                ibp_pkg::REG_PAD_RIGHT:     pad_right_reg     <= cfg_data[6:0];
                ibp_pkg::REG_PAD_MODE:      pad_mode_reg      <= cfg_data[1:0];
                ibp_pkg::REG_FILL_VALUE:    fill_value_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign cfg.source_width  = source_width_reg;
    assign cfg.source_height = source_height_reg;
    assign cfg.pad_top       = pad_top_reg;
    assign cfg.pad_bottom    = pad_bottom_reg;
    assign cfg.pad_left      = pad_left_reg;
    assign cfg.pad_right     = pad_right_reg;
    assign cfg.pad_mode      = pad_mode_reg;
    assign cfg.fill_value    = fill_value_reg;

    // Front: range checks and coordinate mapping, straight off the input word
    ibp_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .in_word (in_word),
        .cfg     (cfg),
        .cmd     (front_cmd)
    );

    // Command queue: full here is the input-side back pressure
    ibp_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (full),
        .valid    (cmd_valid),
        .pop      (cmd_pop),
        .head_cmd (head_cmd)
    );

    // Back: frame store access and result queue
    ibp_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word)
    );

endmodule

FILE: sim/image_border_padding_test.sv
// image_border_padding_test: self-checking testbench for the border padding engine.
// Drives pixel writes and padded reads through all four padding modes.
// Depends on ibp_pkg and image_border_padding under rtl/core.
module image_border_padding_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W  = 128;
    localparam int MAX_H  = 128;
    localparam int MAX_CH = 3;
    localparam int PLANE  = MAX_W * MAX_H;

    localparam int PHASES     = 12;   // random register settings
    localparam int PHASE_WORDS = 40;  // random words per setting
    localparam int FILL_AREA  = 16;   // sources up to this size get fully written

    // One line of the directed table: either a register write or an input word.
    // typed rows carry their expected result; the others go to the predictor.
    typedef struct packed {
        logic                            is_cfg;
        logic [ibp_pkg::REG_INDEX_W-1:0] reg_idx;
        logic [ibp_pkg::CFG_DATA_W-1:0]  reg_val;
        ibp_pkg::in_word_t               w;
        logic                            typed;
        ibp_pkg::out_word_t              want;
    } step_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    ibp_pkg::in_word_t               in_word = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    ibp_pkg::out_word_t              out_word;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ibp_pkg::REG_INDEX_W-1:0] cfg_index = '0;
    logic [ibp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor state: register shadow plus the planar source store.
    ibp_pkg::cfg_t cfg_shadow;
    logic [7:0]    src_pixels [MAX_CH*PLANE];
    bit            src_written [MAX_CH*PLANE];

    ibp_pkg::out_word_t due_pixels [$];   // results owed by the block, oldest first
    int        mismatch_count = 0;
    int        burst_left = 0;
    int        rx_run = 0;
    bit        rx_hold = 1'b0;

    step_t directed [$];

    image_border_padding #(
        .MAX_WIDTH    (MAX_W),
        .MAX_HEIGHT   (MAX_H),
        .MAX_CHANNELS (MAX_CH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Hard stop; a correct run finishes far earlier.
    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Padded coordinate p on one axis back to a source coordinate.
    // pre is the border ahead of the source, n the source size.
    function automatic int map_coord(int p, int pre, int n, output bit in_src);
        int last;
        last = pre + n;
        in_src = (p >= pre) && (p < last);
        if (in_src)
            return p - pre;
        if (p < pre)
        begin
            case (cfg_shadow.pad_mode)
                ibp_pkg::MODE_CLAMP:  return 0;
                ibp_pkg::MODE_MIRROR: return pre - p - 1;   // edge pixel repeated
                default:              return n - (pre - p); // wraps from far edge
            endcase
        end
        case (cfg_shadow.pad_mode)
            ibp_pkg::MODE_CLAMP:  return n - 1;
            ibp_pkg::MODE_MIRROR: return n - 1 - (p - last);
            default:              return p - last;
        endcase
    endfunction

    // Result of one word under the current registers and store.
    // rd_at / wr_at give the store entry touched, or -1.
    function automatic ibp_pkg::out_word_t padded_pixel(ibp_pkg::in_word_t w,
                                                        output int rd_at,
                                                        output int wr_at);
        ibp_pkg::out_word_t r;
        int sw, sh, pt, pb, pl, pr, x, y, base, sx, sy;
        bit in_x, in_y, wide;
        r.pixel_out = '0;
        r.status = 1'b1;
        rd_at = -1;
        wr_at = -1;
        sw = int'(cfg_shadow.source_width);
        sh = int'(cfg_shadow.source_height);
        pt = int'(cfg_shadow.pad_top);
        pb = int'(cfg_shadow.pad_bottom);
        pl = int'(cfg_shadow.pad_left);
        pr = int'(cfg_shadow.pad_right);
        x = int'(w.coord_x);
        y = int'(w.coord_y);
        // bad geometry or bad channel: no effect, error status
        if (sw < 1 || sw > MAX_W || sh < 1 || sh > MAX_H || int'(w.channel) >= MAX_CH)
            return r;
        base = int'(w.channel) * PLANE;
        if (w.opcode == ibp_pkg::OP_WRITE)
        begin
            if (x < sw && y < sh)
            begin
                wr_at = base + y * MAX_W + x;
                r.status = 1'b0;
            end
            return r;
        end
        // mirror and wrap cannot reach past the far edge of the source
        wide = (cfg_shadow.pad_mode == ibp_pkg::MODE_MIRROR ||
                cfg_shadow.pad_mode == ibp_pkg::MODE_WRAP) &&
               (pt > sh || pb > sh || pl > sw || pr > sw);
        if (x >= sw + pl + pr || y >= sh + pt + pb || wide)
            return r;
        sx = map_coord(x, pl, sw, in_x);
        sy = map_coord(y, pt, sh, in_y);
        r.status = 1'b0;
        if (cfg_shadow.pad_mode == ibp_pkg::MODE_FILL && !(in_x && in_y))
            r.pixel_out = cfg_shadow.fill_value;
        else if (sx >= 0 && sx < sw && sy >= 0 && sy < sh)
        begin
            rd_at = base + sy * MAX_W + sx;
            r.pixel_out = src_pixels[rd_at];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Push one word in bursts; the prediction is made at the accepting edge.
    task automatic send_word(ibp_pkg::in_word_t w, bit typed, ibp_pkg::out_word_t want);
        bit stalled;
        int rd_at, wr_at;
        ibp_pkg::out_word_t got;
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // long bursts now and then give stretches with no input gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        push <= 1'b1;
        in_word <= w;
        // full only moves at rising edges, so the value at the falling edge
        // is the one the next rising edge sees
        do
        begin
            @(negedge clk);
            stalled = full;
            @(posedge clk);
        end
        while (stalled);
        got = padded_pixel(w, rd_at, wr_at);
        if (wr_at >= 0)
        begin
            src_pixels[wr_at] = w.pixel_in;
            src_written[wr_at] = 1'b1;
        end
        due_pixels = {due_pixels, (typed ? want : got)};
    endtask

    // Leaves cfg_valid high so back-to-back writes need no toggle.
    task automatic write_reg(logic [ibp_pkg::REG_INDEX_W-1:0] idx,
                             logic [ibp_pkg::CFG_DATA_W-1:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        case (idx)
            ibp_pkg::REG_SOURCE_WIDTH:  cfg_shadow.source_width = val;
            ibp_pkg::REG_SOURCE_HEIGHT: cfg_shadow.source_height = val;
            ibp_pkg::REG_PAD_TOP:       cfg_shadow.pad_top = val[6:0];
            ibp_pkg::REG_PAD_BOTTOM:    cfg_shadow.pad_bottom = val[6:0];
            ibp_pkg::REG_PAD_LEFT:      cfg_shadow.pad_left = val[6:0];
            ibp_pkg::REG_PAD_RIGHT:     cfg_shadow.pad_right = val[6:0];
            ibp_pkg::REG_PAD_MODE:      cfg_shadow.pad_mode = val[1:0];
            default:                    cfg_shadow.fill_value = val;
        endcase
    endtask

    // Every word yields a result, so an empty queue means the block is idle.
    task automatic settle();
        push <= 1'b0;
        cfg_valid <= 1'b0;
        while (due_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------

    // Source coordinate for a write; large sources favor the edges, which is
    // where the border modes fetch from.
    function automatic int pick_src_coord(int n);
        int r;
        if (n < 1 || n > MAX_W || $urandom_range(0, 11) == 0)
            return $urandom_range(0, 511);
        if (n <= 8)
            return $urandom_range(0, n - 1);
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 2);
        if (r < 8)
            return $urandom_range(n - 3, n - 1);
        return $urandom_range(0, n - 1);
    endfunction

    // Padded coordinate for a read: anywhere, around either source edge,
    // or past the padded image.
    function automatic int pick_pad_coord(int pre, int n, int post);
        int total, last, r;
        total = pre + n + post;
        last = pre + n;
        if (n < 1 || total > 511)
            return $urandom_range(0, 511);
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom_range(total, 511);
        if (r < 4)
            return $urandom_range(0, total - 1);
        if (r < 7)
            return $urandom_range((pre > 3) ? pre - 3 : 0,
                                  (pre + 2 < total) ? pre + 2 : total - 1);
        return $urandom_range((last > 3) ? last - 3 : 0,
                              (last + 2 < total) ? last + 2 : total - 1);
    endfunction

    function automatic int pick_pad(int n);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 127;
        if (r == 1)
            return (n + 1 < 127) ? n + 1 : 127;  // just too wide to mirror or wrap
        return $urandom_range(0, (n < 127) ? n : 127);
    endfunction

    // Random word; reads are redrawn until they miss the store or hit a
    // written entry, and fall back to a write otherwise.
    task automatic pick_word(output ibp_pkg::in_word_t w);
        int sw, sh, r, rd_at, wr_at;
        bit safe;
        ibp_pkg::out_word_t unused;
        sw = int'(cfg_shadow.source_width);
        sh = int'(cfg_shadow.source_height);
        safe = 1'b0;
        for (int t = 0; t < 40 && !safe; t++)
        begin
            r = $urandom_range(0, 99);
            w.pixel_in = 8'($urandom);
            w.channel = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            if (r < 6)
            begin
                w.opcode = 1'($urandom);
                w.channel = 2'($urandom);
                w.coord_x = 9'($urandom);
                w.coord_y = 9'($urandom);
            end
            else if (r < 40)
            begin
                w.opcode = ibp_pkg::OP_WRITE;
                w.coord_x = 9'(pick_src_coord(sw));
                w.coord_y = 9'(pick_src_coord(sh));
            end
            else
            begin
                w.opcode = ibp_pkg::OP_READ;
                w.coord_x = 9'(pick_pad_coord(int'(cfg_shadow.pad_left), sw,
                                              int'(cfg_shadow.pad_right)));
                w.coord_y = 9'(pick_pad_coord(int'(cfg_shadow.pad_top), sh,
                                              int'(cfg_shadow.pad_bottom)));
            end
            unused = padded_pixel(w, rd_at, wr_at);
            safe = (rd_at < 0) || src_written[rd_at];
        end
        if (!safe)
            w.opcode = ibp_pkg::OP_WRITE;
    endtask

    // New register set for one phase; the first three are fixed extremes.
    task automatic pick_setup(int k);
        int sw, sh, r;
        int pads [4];
        logic [1:0] mode;
        logic [7:0] fill;
        mode = 2'($urandom_range(0, 3));
        fill = 8'($urandom);
        r = $urandom_range(0, 9);
        if (k == 0)
        begin
            // largest source, widest borders, padded size 382
            sw = MAX_W;
            sh = MAX_H;
            pads = '{127, 127, 127, 127};
            mode = ibp_pkg::MODE_WRAP;
            fill = 8'hFF;
        end
        else if (k == 1)
        begin
            sw = 1;
            sh = 1;
            pads = '{$urandom_range(0, 2), $urandom_range(0, 2),
                     $urandom_range(0, 2), $urandom_range(0, 2)};
            mode = ibp_pkg::MODE_MIRROR;
            fill = 8'h00;
        end
        else if (k == 2)
        begin
            sw = 1;
            sh = 1;
            pads = '{127, 127, 127, 127};
            mode = ibp_pkg::MODE_CLAMP;
        end
        else
        begin
            if (r == 0)
            begin
                // bad geometry: zero or above the store size
                sw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_W + 1, 255);
                sh = $urandom_range(1, 6);
            end
            else if (r == 1)
            begin
                sw = $urandom_range(1, 6);
                sh = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_H + 1, 255);
            end
            else if (r < 4)
            begin
                sw = $urandom_range(100, MAX_W);
                sh = $urandom_range(100, MAX_H);
            end
            else
            begin
                sw = $urandom_range(1, 6);
                sh = $urandom_range(1, 6);
            end
            pads = '{pick_pad(sh), pick_pad(sh), pick_pad(sw), pick_pad(sw)};
        end
        write_reg(ibp_pkg::REG_SOURCE_WIDTH, 8'(sw));
        write_reg(ibp_pkg::REG_SOURCE_HEIGHT, 8'(sh));
        write_reg(ibp_pkg::REG_PAD_TOP, 8'(pads[0]));
        write_reg(ibp_pkg::REG_PAD_BOTTOM, 8'(pads[1]));
        write_reg(ibp_pkg::REG_PAD_LEFT, 8'(pads[2]));
        write_reg(ibp_pkg::REG_PAD_RIGHT, 8'(pads[3]));
        write_reg(ibp_pkg::REG_PAD_MODE, 8'(mode));
        write_reg(ibp_pkg::REG_FILL_VALUE, fill);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------

    function automatic step_t word_row(logic op, int ch, int x, int y, int pix,
                                       bit typed, int px_exp, bit st_exp);
        step_t s;
        s = '0;
        s.w.opcode = op;
        s.w.channel = 2'(ch);
        s.w.coord_x = 9'(x);
        s.w.coord_y = 9'(y);
        s.w.pixel_in = 8'(pix);
        s.typed = typed;
        s.want.pixel_out = 8'(px_exp);
        s.want.status = st_exp;
        return s;
    endfunction

    function automatic step_t reg_row(logic [ibp_pkg::REG_INDEX_W-1:0] idx, int val);
        step_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = 8'(val);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------

    // Runs of steady popping and stalls of random length come in random order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_run == 0)
            begin
                rx_hold = ($urandom_range(0, 2) == 0);
                rx_run = rx_hold ? $urandom_range(1, 10) : $urandom_range(1, 40);
            end
            rx_run--;
            pop <= !rx_hold;
        end
    end

    task automatic note_mismatch(string what, ibp_pkg::out_word_t want,
                                 ibp_pkg::out_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected pixel %02h status %0d, got pixel %02h status %0d",
                     $realtime, what, want.pixel_out, want.status,
                     got.pixel_out, got.status);
    endtask

    // Sampled at the falling edge: pop, empty and out_word hold the values
    // the next rising edge will act on.
    always @(negedge clk)
    begin
        ibp_pkg::out_word_t want;
        if (rst_n && pop && !empty)
        begin
            if (due_pixels.size() == 0)
                note_mismatch("result with nothing owed", '0, out_word);
            else
            begin
                want = due_pixels.pop_front();
                if (out_word.pixel_out !== want.pixel_out)
                    note_mismatch("pixel_out differs", want, out_word);
                else if (out_word.status !== want.status)
                    note_mismatch("status differs", want, out_word);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        ibp_pkg::in_word_t w;
        int sw, sh;
        ibp_pkg::out_word_t none;
        none = '0;

        cfg_shadow = '0;
        cfg_shadow.source_width = 8'(MAX_W);
        cfg_shadow.source_height = 8'(MAX_H);

        // Store addressing ignores the source width, so entries stay valid
        // across geometry changes. Starts at reset geometry 128x128,
        // no border, constant mode, fill 0.
        directed = '{
            word_row(ibp_pkg::OP_WRITE, 0,   0,   0, 'hA5, 1, 0, 0),
            word_row(ibp_pkg::OP_WRITE, 2, 127, 127, 'hFF, 1, 0, 0),   // far corner, top plane
            word_row(ibp_pkg::OP_WRITE, 1,   5,   3, 'h00, 1, 0, 0),
            word_row(ibp_pkg::OP_WRITE, 3,   0,   0, 'h5A, 1, 0, 1),   // channel past last plane
            word_row(ibp_pkg::OP_WRITE, 0, 128,   0, 'h11, 1, 0, 1),   // column past source
            word_row(ibp_pkg::OP_WRITE, 0,   0, 128, 'h22, 1, 0, 1),   // row past source
            word_row(ibp_pkg::OP_WRITE, 0, 511, 511, 'hFF, 1, 0, 1),
            word_row(ibp_pkg::OP_READ,  0,   0,   0, 'h00, 1, 'hA5, 0),
            word_row(ibp_pkg::OP_READ,  2, 127, 127, 'h00, 1, 'hFF, 0),
            word_row(ibp_pkg::OP_READ,  1,   5,   3, 'hFF, 0, 0, 0),
            word_row(ibp_pkg::OP_READ,  0, 128,   0, 'h00, 1, 0, 1),   // outside padded image
            word_row(ibp_pkg::OP_READ,  0, 511, 511, 'h00, 1, 0, 1),
            word_row(ibp_pkg::OP_READ,  3,   0,   0, 'h00, 1, 0, 1),
            // two-pixel border all round
            reg_row(ibp_pkg::REG_PAD_TOP, 2),
            reg_row(ibp_pkg::REG_PAD_BOTTOM, 2),
            reg_row(ibp_pkg::REG_PAD_LEFT, 2),
            reg_row(ibp_pkg::REG_PAD_RIGHT, 2),
            reg_row(ibp_pkg::REG_FILL_VALUE, 'h3C),
            word_row(ibp_pkg::OP_READ,  0,   0,   0, 'h00, 1, 'h3C, 0),  // corner reads fill
            word_row(ibp_pkg::OP_READ,  0,   2,   2, 'h00, 1, 'hA5, 0),
            word_row(ibp_pkg::OP_READ,  2, 131, 131, 'h00, 1, 'h3C, 0),
            reg_row(ibp_pkg::REG_PAD_MODE, ibp_pkg::MODE_CLAMP),
            word_row(ibp_pkg::OP_READ,  0,   0,   0, 'h00, 1, 'hA5, 0),
            word_row(ibp_pkg::OP_READ,  2, 130, 131, 'h00, 1, 'hFF, 0),
            reg_row(ibp_pkg::REG_PAD_MODE, ibp_pkg::MODE_MIRROR),
            word_row(ibp_pkg::OP_READ,  0,   1,   1, 'h00, 1, 'hA5, 0),
            word_row(ibp_pkg::OP_READ,  2, 130, 130, 'h00, 0, 0, 0),
            reg_row(ibp_pkg::REG_PAD_MODE, ibp_pkg::MODE_WRAP),
            word_row(ibp_pkg::OP_READ,  2,   1,   1, 'h00, 1, 'hFF, 0),  // wraps to far corner
            word_row(ibp_pkg::OP_READ,  0, 130, 130, 'h00, 1, 'hA5, 0),
            // border wider than a one-column source: every read fails
            reg_row(ibp_pkg::REG_SOURCE_WIDTH, 1),
            word_row(ibp_pkg::OP_READ,  0,   2,   2, 'h00, 1, 0, 1),
            // zero and oversized widths disable the block
            reg_row(ibp_pkg::REG_SOURCE_WIDTH, 0),
            word_row(ibp_pkg::OP_WRITE, 0,   0,   0, 'h77, 1, 0, 1),
            reg_row(ibp_pkg::REG_SOURCE_WIDTH, 200),
            word_row(ibp_pkg::OP_READ,  0,   0,   0, 'h00, 1, 0, 1),
            reg_row(ibp_pkg::REG_SOURCE_WIDTH, MAX_W)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                settle();
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_word(directed[i].w, directed[i].typed, directed[i].want);
            end
        end

        for (int k = 0; k < PHASES; k++)
        begin
            settle();
            pick_setup(k);
            sw = int'(cfg_shadow.source_width);
            sh = int'(cfg_shadow.source_height);
            // small sources get every pixel of every plane written first,
            // so reads can land anywhere
            if (sw >= 1 && sh >= 1 && sw * sh <= FILL_AREA)
            begin
                for (int ch = 0; ch < MAX_CH; ch++)
                    for (int y = 0; y < sh; y++)
                        for (int x = 0; x < sw; x++)
                        begin
                            w.opcode = ibp_pkg::OP_WRITE;
                            w.channel = 2'(ch);
                            w.coord_x = 9'(x);
                            w.coord_y = 9'(y);
                            w.pixel_in = 8'($urandom);
                            send_word(w, 1'b0, none);
                        end
            end
            repeat (PHASE_WORDS)
            begin
                pick_word(w);
                send_word(w, 1'b0, none);
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
